/* rtl/core/cdsw_pkg.sv */
package cdsw_pkg;

    localparam logic [7:0] CHAR_FIRST    = 8'h20;
    localparam logic [7:0] CHAR_LAST     = 8'h7B;
    localparam logic [7:0] ADDR_BASE     = 8'b1010_0000;
    localparam logic [7:0] CTRL_BASE     = 8'b1110_0000;
    localparam logic [7:0] BRIGHT_MASK   = 8'b0000_0111;
    localparam logic [7:0] DIGIT_MAX     = 8'd7;
    localparam int         ROWS_PER_CHAR = 7;
    localparam int         FRAME_BITS    = 64;
    localparam int         CDSW_FIFO_DEPTH = 4;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_CTRL = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [7:0] digit_pos;
        logic [2:0] brightness;
    } in_word_t;

    typedef struct packed {
        logic data_bit;
        logic load_release;
        logic last;
    } out_word_t;

    function automatic logic [55:0] glyph_rows(input logic [6:0] idx);
        logic [55:0] rows;
        case (idx)
            7'd0:  rows = 56'h00000000000000;
            7'd1:  rows = 56'h04040404040004;
            7'd2:  rows = 56'h0A0A0000000000;
            7'd3:  rows = 56'h0A0A1F0A1F0A0A;
            7'd4:  rows = 56'h040F140E050604;
            7'd5:  rows = 56'h18190204081303;
            7'd6:  rows = 56'h0814081412110E;
            7'd7:  rows = 56'h02020400000000;
            7'd8:  rows = 56'h04080808080804;
            7'd9:  rows = 56'h02010101010102;
            7'd10: rows = 56'h00110A1F0A1100;
            7'd11: rows = 56'h0004041F040400;
            7'd12: rows = 56'h00000000080810;
            7'd13: rows = 56'h0000001F000000;
            7'd14: rows = 56'h00000000001818;
            7'd15: rows = 56'h00010204081000;
            7'd16: rows = 56'h0E11131519110E;
            7'd17: rows = 56'h040C040404040E;
            7'd18: rows = 56'h0E01010E10101F;
            7'd19: rows = 56'h1E01010E01011E;
            7'd20: rows = 56'h010305091F0101;
            7'd21: rows = 56'h1F10101E01110E;
            7'd22: rows = 56'h0E10101E11110E;
            7'd23: rows = 56'h1F010102040810;
            7'd24: rows = 56'h0E11110E11110E;
            7'd25: rows = 56'h0E11110F020408;
            7'd26: rows = 56'h00000C0C000C0C;
            7'd27: rows = 56'h00000C0C000408;
            7'd28: rows = 56'h02040810080402;
            7'd29: rows = 56'h00001F001F0000;
            7'd30: rows = 56'h08040201020408;
            7'd31: rows = 56'h0E110106080008;
            7'd32: rows = 56'h0E11171517100F;
            7'd33: rows = 56'h040A111F111111;
            7'd34: rows = 56'h1E11111E11111E;
            7'd35: rows = 56'h0E11101010110E;
            7'd36: rows = 56'h1E11111111111E;
            7'd37: rows = 56'h1F10101E10101F;
            7'd38: rows = 56'h1F10101E101010;
            7'd39: rows = 56'h0E11101013110F;
            7'd40: rows = 56'h1111111F111111;
            7'd41: rows = 56'h0E04040404040E;
            7'd42: rows = 56'h1F02020212120C;
            7'd43: rows = 56'h11121418141211;
            7'd44: rows = 56'h1010101010101F;
            7'd45: rows = 56'h111B1511111111;
            7'd46: rows = 56'h11191513111111;
            7'd47: rows = 56'h0E11111111110E;
            7'd48: rows = 56'h1E11111E101010;
            7'd49: rows = 56'h0E11111115130F;
            7'd50: rows = 56'h1E11111E141211;
            7'd51: rows = 56'h0F10100E01011E;
            7'd52: rows = 56'h1F040404040404;
            7'd53: rows = 56'h1111111111110E;
            7'd54: rows = 56'h11111111110A04;
            7'd55: rows = 56'h11111111151B11;
            7'd56: rows = 56'h11110A040A1111;
            7'd57: rows = 56'h1111110A040404;
            7'd58: rows = 56'h1F01020408101F;
            7'd59: rows = 56'h1C10101010101C;
            7'd60: rows = 56'h00100804020100;
            7'd61: rows = 56'h07010101010107;
            7'd62: rows = 56'h040A1100000000;
            7'd63: rows = 56'h0000000000001F;
            7'd64: rows = 56'h02020100000000;
            7'd65: rows = 56'h00000E1111130D;
            7'd66: rows = 56'h10101E1111111E;
            7'd67: rows = 56'h00000F1010100F;
            7'd68: rows = 56'h01010F1111110F;
            7'd69: rows = 56'h00000E111F100F;
            7'd70: rows = 56'h02050E04040404;
            7'd71: rows = 56'h00000E110F010E;
            7'd72: rows = 56'h10101E11111111;
            7'd73: rows = 56'h04000404040404;
            7'd74: rows = 56'h04000404041408;
            7'd75: rows = 56'h10101112141A11;
            7'd76: rows = 56'h04040404040404;
            7'd77: rows = 56'h00001A15151515;
            7'd78: rows = 56'h00001619111111;
            7'd79: rows = 56'h00000E1111110E;
            7'd80: rows = 56'h00001E111E1010;
            7'd81: rows = 56'h00000F110F0101;
            7'd82: rows = 56'h00001619101010;
            7'd83: rows = 56'h00000F100E011E;
            7'd84: rows = 56'h04040E04040406;
            7'd85: rows = 56'h0000111111130D;
            7'd86: rows = 56'h00001111110A04;
            7'd87: rows = 56'h0000111115150A;
            7'd88: rows = 56'h0000110A040A11;
            7'd89: rows = 56'h000011111F010E;
            7'd90: rows = 56'h00001F0204081F;
            7'd91: rows = 56'h04080810080804;
            default: rows = 56'h00000000000000;
        endcase
        return rows;
    endfunction

endpackage

/* rtl/core/char_display_serial_writer_top.sv */
// Serial writer for an eight-digit 5x7 dot-matrix display. Each accepted word is a
// command: a character write yields 64 result words (address byte, then seven font
// rows), a control write yields 8 (brightness byte). Result words carry one serial
// bit each, LSB first, with load_release on every eighth bit and last on the final
// bit of the command. The single output shift register emits one bit per cycle while
// m_ready does not hold the output, and commands follow back to back with no gap
// while commands are queued. Commands wait in a FifoDepth-entry queue RAM; an
// accepted command is read from the RAM into the stage register, then the shift register.
module char_display_serial_writer_top
    import cdsw_pkg::*;
#(
    parameter int FifoDepth = CDSW_FIFO_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AddrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
    localparam int CntW  = $clog2(FifoDepth + 1);
    localparam int LeftW = $clog2(FRAME_BITS + 1);

    logic [AddrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  fifo_cnt_reg, fifo_cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             stage_valid_reg, stage_valid_next;
    logic [FRAME_BITS-1:0] stage_frame_reg, stage_frame_next;
    logic             stage_long_reg, stage_long_next;
    logic [FRAME_BITS-1:0] ser_frame_reg, ser_frame_next;
    logic [LeftW-1:0] ser_left_reg, ser_left_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_word_reg, m_word_next;

    logic             push, pop, emit, ser_free, stage_take;
    in_word_t         rd_word;
    logic [FRAME_BITS-1:0] built_frame;
    logic [7:0]       code_adj, digit_adj;
    logic [55:0]      rows;

    assign s_ready = (fifo_cnt_reg < CntW'(FifoDepth));
    assign push    = s_valid && s_ready;
    assign pop     = (fifo_cnt_reg != '0) && !rd_pend_reg && !stage_valid_reg;

    cdsw_ram #(
        .Width($bits(in_word_t)),
        .Depth(FifoDepth)
    ) u_queue (
        .aclk   (aclk),
        .wr_en  (push),
        .wr_addr(wr_ptr_reg),
        .wr_data(s_data),
        .rd_en  (pop),
        .rd_addr(rd_ptr_reg),
        .rd_data(rd_word)
    );

    always_comb begin
        code_adj  = rd_word.char_code;
        digit_adj = rd_word.digit_pos;
        if (code_adj < CHAR_FIRST || code_adj > CHAR_LAST) begin
            code_adj = CHAR_FIRST;
        end
        if (digit_adj > DIGIT_MAX) begin
            digit_adj = 8'd0;
        end
        rows = glyph_rows(7'(code_adj - CHAR_FIRST));
        built_frame = '0;
        if (rd_word.command == CMD_CTRL) begin
            built_frame[7:0] = CTRL_BASE | ({5'd0, rd_word.brightness} & BRIGHT_MASK);
        end else begin
            built_frame[7:0] = ADDR_BASE | digit_adj;
            for (int r = 0; r < ROWS_PER_CHAR; r++) begin
                built_frame[8*(r+1) +: 8] = rows[55-8*r -: 8];
            end
        end
    end

    assign emit       = (!m_valid_reg || m_ready) && (ser_left_reg != '0);
    assign ser_free   = (ser_left_reg == '0) || (emit && ser_left_reg == LeftW'(1));
    assign stage_take = ser_free && stage_valid_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AddrW'(FifoDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AddrW'(FifoDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fifo_cnt_next = fifo_cnt_reg + CntW'(push) - CntW'(pop);
        rd_pend_next  = pop;

        stage_valid_next = stage_valid_reg;
        stage_frame_next = stage_frame_reg;
        stage_long_next  = stage_long_reg;
        if (stage_take) begin
            stage_valid_next = 1'b0;
        end
        if (rd_pend_reg) begin
            stage_valid_next = 1'b1;
            stage_frame_next = built_frame;
            stage_long_next  = (rd_word.command == CMD_CHAR);
        end

        ser_frame_next = ser_frame_reg;
        ser_left_next  = ser_left_reg;
        m_word_next    = m_word_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next              = 1'b1;
            m_word_next.data_bit      = ser_frame_reg[0];
            m_word_next.load_release  = (ser_left_reg[2:0] == 3'd1);
            m_word_next.last          = (ser_left_reg == LeftW'(1));
            ser_frame_next            = ser_frame_reg >> 1;
            ser_left_next             = ser_left_reg - 1'b1;
        end
        if (stage_take) begin
            ser_frame_next = stage_frame_reg;
            ser_left_next  = stage_long_reg ? LeftW'(FRAME_BITS) : LeftW'(8);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            fifo_cnt_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            stage_valid_reg <= 1'b0;
            ser_left_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            fifo_cnt_reg    <= fifo_cnt_next;
            rd_pend_reg     <= rd_pend_next;
            stage_valid_reg <= stage_valid_next;
            ser_left_reg    <= ser_left_next;
            m_valid_reg     <= m_valid_next;
        end
        stage_frame_reg <= stage_frame_next;
        stage_long_reg  <= stage_long_next;
        ser_frame_reg   <= ser_frame_next;
        m_word_reg      <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= CntW'(FifoDepth))
        else $error("queue count over depth");

    a_pend_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> !stage_valid_reg)
        else $error("queue read landed on a full stage");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_word_reg.last) |-> m_word_reg.load_release)
        else $error("last word does not close a byte");

    a_left_len: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_take |=> (ser_left_reg == LeftW'(FRAME_BITS) || ser_left_reg == LeftW'(8)))
        else $error("bad frame length on load");

endmodule

/* rtl/core/cdsw_ram.sv */
module cdsw_ram #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
    input  logic [Width-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
    output logic [Width-1:0]                        rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
